>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in the next cycle");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed in the next cycle");

`endif

>>> hdl/mwsp_pkg.sv
// Types and constants of the MIDI wavetable sample player.
package mwsp_pkg;

   localparam int SLOT_LENGTH   = 256;
   localparam int FRACTION_BITS = 10;
   localparam int STEP_WIDTH    = 16;

   localparam int STORE_DEPTH = 32768;
   localparam int STORE_AW    = 15;
   localparam int STEP_DEPTH  = 128;
   localparam int STEP_AW     = 7;

   localparam logic [31:0] SLOT_LIMIT  = 32'(SLOT_LENGTH - 1);
   localparam logic [31:0] SLOT_SCALE  = 32'(SLOT_LENGTH);

   localparam logic [7:0] MSG_NOTE_ON      = 8'h90;
   localparam logic [7:0] MSG_CTRL         = 8'hB0;
   localparam logic [6:0] CTRL_SLOT_SELECT = 7'd16;
   localparam logic [6:0] SLOT_AT_RESET    = 7'd18;

   typedef enum logic [1:0] {
      KIND_TICK        = 2'd0,
      KIND_MIDI        = 2'd1,
      KIND_SAMPLE_LOAD = 2'd2,
      KIND_STEP_LOAD   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PS_IDLE     = 3'd0,
      PS_NOTE     = 3'd1,
      PS_VELOCITY = 3'd2,
      PS_CTRL_NUM = 3'd3,
      PS_CTRL_VAL = 3'd4
   } parse_state_type;

endpackage

>>> hdl/midi_wavetable_sample_player.sv
// A request passes the read stage, then the output register, which offers its result.
// One request per cycle while req_stall is low; a tick reads the sample memory and a
// Note On reads the step table once, with the read data forwarded to the next item.
// Reset (synchronous, active high) restores position, step, slot, level and parser;
// the sample memory and step table keep their contents and need no clearing pass.
module midi_wavetable_sample_player import mwsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_midi_byte,
   input  logic [14:0] req_load_addr,
   input  logic [15:0] req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_audio_level,
   output logic        rsp_level_updated,
   output logic        rsp_playing
);

   // Architectural state.
   logic [31:0]           pos_ff, pos_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [6:0]            slot_ff, slot_in;
   logic                  stop_ff, stop_in;
   logic [7:0]            level_ff, level_in;
   parse_state_type       parse_ff, parse_in;
   logic [6:0]            held_ff, held_in;

   // Read stage.
   logic s1_valid_ff, s1_valid_in;
   logic s1_read_tick_ff, s1_read_tick_in;
   logic s1_idx_nz_ff, s1_idx_nz_in;
   logic s1_note_ff, s1_note_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_level_ff;
   logic       rsp_updated_ff;
   logic       rsp_playing_ff;

   logic                  s1_move, accept;
   logic                  s1_zero_stop, stop_eff;
   logic [STEP_WIDTH-1:0] step_eff;
   logic [31:0]           idx;
   logic                  in_range;
   logic                  tick_go, midi_go;
   logic [6:0]            data7;
   logic                  note_fire, held_load, slot_load;

   logic                  smp_rd_en, smp_wr_en;
   logic [STORE_AW-1:0]   smp_rd_addr;
   logic [7:0]            smp_rd;
   logic                  stp_rd_en, stp_wr_en;
   logic [STEP_WIDTH-1:0] stp_rd;

   mwsp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_sample_store (
      .clock   (clock),
      .wr_en   (smp_wr_en),
      .wr_addr (req_load_addr[STORE_AW-1:0]),
      .wr_data (req_load_data[7:0]),
      .rd_en   (smp_rd_en),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_rd)
   );

   mwsp_ram #(.WIDTH(STEP_WIDTH), .DEPTH(STEP_DEPTH)) u_step_table (
      .clock   (clock),
      .wr_en   (stp_wr_en),
      .wr_addr (req_load_addr[STEP_AW-1:0]),
      .wr_data (STEP_WIDTH'(req_load_data)),
      .rd_en   (stp_rd_en),
      .rd_addr (held_ff[STEP_AW-1:0]),
      .rd_data (stp_rd)
   );

   // Handshake. The read stage only holds when the output register is full and stalled,
   // and the memories keep their read data while it holds.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   // Results of the item in the read stage, forwarded to the item entering now.
   assign s1_zero_stop = s1_read_tick_ff && s1_idx_nz_ff && (smp_rd == 8'd0);
   assign stop_eff     = stop_ff || (s1_move && s1_zero_stop);
   assign step_eff     = (s1_move && s1_note_ff) ? stp_rd : step_ff;

   assign idx         = pos_ff >> FRACTION_BITS;
   assign in_range    = idx < SLOT_LIMIT;
   assign tick_go     = accept && (req_kind == KIND_TICK) && !stop_eff;
   assign midi_go     = accept && (req_kind == KIND_MIDI);
   assign data7       = req_midi_byte[6:0];
   assign smp_rd_en   = tick_go && in_range;
   assign smp_rd_addr = STORE_AW'((32'(slot_ff) * SLOT_SCALE) + idx);
   assign smp_wr_en   = accept && (req_kind == KIND_SAMPLE_LOAD);
   assign stp_wr_en   = accept && (req_kind == KIND_STEP_LOAD);
   assign stp_rd_en   = note_fire;

   // Parser next state.
   always_comb begin
      parse_in = parse_ff;
      if (midi_go) begin
         unique case (parse_ff)
            PS_NOTE:     parse_in = PS_VELOCITY;
            PS_VELOCITY: parse_in = PS_IDLE;
            PS_CTRL_NUM: parse_in = PS_CTRL_VAL;
            PS_CTRL_VAL: parse_in = PS_IDLE;
            default: begin
               if (req_midi_byte == MSG_NOTE_ON) begin
                  parse_in = PS_NOTE;
               end else if (req_midi_byte == MSG_CTRL) begin
                  parse_in = PS_CTRL_NUM;
               end else begin
                  parse_in = PS_IDLE;
               end
            end
         endcase
      end
   end

   // Parser outputs.
   always_comb begin
      note_fire = 1'b0;
      held_load = 1'b0;
      slot_load = 1'b0;
      if (midi_go) begin
         unique case (parse_ff)
            PS_NOTE:     held_load = 1'b1;
            PS_VELOCITY: note_fire = (data7 != 7'd0);
            PS_CTRL_NUM: held_load = 1'b1;
            PS_CTRL_VAL: slot_load = (held_ff == CTRL_SLOT_SELECT);
            default:     held_load = 1'b0;
         endcase
      end
   end

   always_comb begin
      held_in = held_load ? data7 : held_ff;
      slot_in = slot_load ? data7 : slot_ff;

      priority if (note_fire) begin
         pos_in = 32'd0;
      end else if (tick_go) begin
         pos_in = in_range ? (pos_ff + 32'(step_eff)) : 32'd0;
      end else begin
         pos_in = pos_ff;
      end

      stop_in  = note_fire ? 1'b0 : stop_eff;
      step_in  = step_eff;
      level_in = (s1_move && s1_read_tick_ff && !s1_zero_stop) ? smp_rd : level_ff;

      s1_valid_in     = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_read_tick_in = accept ? smp_rd_en : s1_read_tick_ff;
      s1_idx_nz_in    = accept ? (idx != 32'd0) : s1_idx_nz_ff;
      s1_note_in      = accept ? note_fire : s1_note_ff;

      rsp_valid_in = s1_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 32'd0;
         step_ff      <= STEP_WIDTH'(1);
         slot_ff      <= SLOT_AT_RESET;
         stop_ff      <= 1'b0;
         level_ff     <= 8'd0;
         parse_ff     <= PS_IDLE;
         held_ff      <= 7'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         step_ff      <= step_in;
         slot_ff      <= slot_in;
         stop_ff      <= stop_in;
         level_ff     <= level_in;
         parse_ff     <= parse_in;
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_tick_ff <= s1_read_tick_in;
      s1_idx_nz_ff    <= s1_idx_nz_in;
      s1_note_ff      <= s1_note_in;
      if (s1_move) begin
         rsp_level_ff   <= level_in;
         rsp_updated_ff <= s1_read_tick_ff && !s1_zero_stop;
         rsp_playing_ff <= !stop_eff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_audio_level   = rsp_level_ff;
   assign rsp_level_updated = rsp_updated_ff;
   assign rsp_playing       = rsp_playing_ff;

endmodule

>>> hdl/mwsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mwsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/mwsp_checker.sv
// Port-level checker for the sample player and its bind to the top level.
`include "assert_macros.svh"

module mwsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_audio_level,
   input logic        rsp_level_updated,
   input logic        rsp_playing
);

   // Nothing is pending right after reset.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A tick that writes a new level cannot have stopped playback.
   `ASSERT_SAME(a_update_playing, clock, reset, rsp_valid && rsp_level_updated, rsp_playing)

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result keeps its level.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_audio_level))

   // The input only backs up behind a result that is held off.
   `ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind midi_wavetable_sample_player mwsp_checker u_mwsp_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the MIDI wavetable sample player.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mwsp_pkg::*;

   localparam int RANDOM_ITEMS   = 1120;
   localparam int TAIL_ITEMS     = 150;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SCRIPT_ROWS    = 25;

   localparam logic [14:0] RESET_SLOT_BASE = 15'(32'(SLOT_AT_RESET) * SLOT_SCALE);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  midi;
      logic [14:0] addr;
      logic [15:0] data;
   } player_req_t;

   typedef struct packed {
      logic [7:0] level;
      logic       updated;
      logic       playing;
   } player_rsp_t;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  midi;
      logic [14:0] addr;
      logic [15:0] data;
      logic        typed;
      logic [7:0]  level;
      logic        updated;
      logic        playing;
   } script_row_t;

   // Rows with typed set carry their own expected result; the rest use the predictor.
   localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
      '{KIND_SAMPLE_LOAD, 8'h00, RESET_SLOT_BASE, 16'hFF80, 1'b1, 8'h00, 1'b0, 1'b1},
      '{KIND_TICK, 8'h00, 15'd0, 16'h0000, 1'b1, 8'h80, 1'b1, 1'b1},
      '{KIND_STEP_LOAD, 8'h00, 15'h7FFF, 16'hFFFF, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_STEP_LOAD, 8'h00, 15'd5, 16'h0400, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_SAMPLE_LOAD, 8'h00, RESET_SLOT_BASE + 15'd1, 16'h00FF, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_SAMPLE_LOAD, 8'h00, RESET_SLOT_BASE + 15'd2, 16'hFF00, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_MIDI, MSG_NOTE_ON, 15'd0, 16'h0000, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_MIDI, 8'h85, 15'd0, 16'h0000, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_MIDI, 8'h01, 15'd0, 16'h0000, 1'b1, 8'h80, 1'b0, 1'b1},
      '{KIND_TICK, 8'hFF, 15'h7FFF, 16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0},
      '{KIND_TICK, 8'h00, 15'd0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      '{KIND_TICK, 8'h00, 15'd0, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0},
      '{KIND_TICK, 8'h00, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, MSG_NOTE_ON, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'h05, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'h00, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, MSG_CTRL, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, {1'b1, CTRL_SLOT_SELECT}, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'hFF, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, MSG_NOTE_ON, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'h7F, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'h80, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, MSG_NOTE_ON, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'hFF, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b0},
      '{KIND_MIDI, 8'h7F, 15'd0, 16'h0000, 1'b1, 8'hFF, 1'b0, 1'b1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_TICK;
   logic [7:0]  req_midi_byte = '0;
   logic [14:0] req_load_addr = '0;
   logic [15:0] req_load_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_audio_level;
   logic        rsp_level_updated;
   logic        rsp_playing;

   midi_wavetable_sample_player dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_midi_byte     (req_midi_byte),
      .req_load_addr     (req_load_addr),
      .req_load_data     (req_load_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_audio_level   (rsp_audio_level),
      .rsp_level_updated (rsp_level_updated),
      .rsp_playing       (rsp_playing)
   );

   // Predicted player state.
   logic [31:0]           play_pos = '0;
   logic [STEP_WIDTH-1:0] play_step = STEP_WIDTH'(1);
   logic [6:0]            play_slot = SLOT_AT_RESET;
   logic                  play_stopped = 1'b0;
   logic [7:0]            play_level = '0;
   parse_state_type       midi_state = PS_IDLE;
   logic [6:0]            midi_held = '0;
   logic [7:0]            sample_mem [STORE_DEPTH];
   bit                    sample_known [STORE_DEPTH];
   logic [STEP_WIDTH-1:0] step_mem [STEP_DEPTH];
   bit                    step_known [STEP_DEPTH];

   player_rsp_t expected_results [$];
   player_rsp_t observed;
   player_rsp_t awaited;
   int          error_count = 0;
   int          results_checked = 0;
   int          items_sent = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   logic        tail_phase = 1'b0;
   int          quiet_cycles = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [STORE_AW-1:0] sample_addr();
      logic [31:0] full;
      full = 32'(play_slot) * SLOT_SCALE + (play_pos >> FRACTION_BITS);
      return full[STORE_AW-1:0];
   endfunction

   function automatic player_rsp_t run_player(input player_req_t item);
      logic [31:0] idx;
      logic [7:0]  smp;
      logic [6:0]  d;
      player_rsp_t res;
      res.updated = 1'b0;
      d = item.midi[6:0];
      case (item.kind)
         KIND_TICK: begin
            if (!play_stopped) begin
               idx = play_pos >> FRACTION_BITS;
               if (idx < SLOT_LIMIT) begin
                  smp = sample_mem[sample_addr()];
                  play_pos = play_pos + 32'(play_step);
                  // A zero sample stops playback, except at the first index of the slot.
                  if (smp == 8'd0 && idx != 0) begin
                     play_stopped = 1'b1;
                  end else begin
                     play_level = smp;
                     res.updated = 1'b1;
                  end
               end else begin
                  play_pos = '0;
               end
            end
         end
         KIND_MIDI: begin
            case (midi_state)
               PS_NOTE: begin
                  midi_held = d;
                  midi_state = PS_VELOCITY;
               end
               PS_VELOCITY: begin
                  if (d != 7'd0) begin
                     play_step = step_mem[midi_held];
                     play_pos = '0;
                     play_stopped = 1'b0;
                  end
                  midi_state = PS_IDLE;
               end
               PS_CTRL_NUM: begin
                  midi_held = d;
                  midi_state = PS_CTRL_VAL;
               end
               PS_CTRL_VAL: begin
                  if (midi_held == CTRL_SLOT_SELECT) play_slot = d;
                  midi_state = PS_IDLE;
               end
               default: begin
                  if (item.midi == MSG_NOTE_ON) midi_state = PS_NOTE;
                  else if (item.midi == MSG_CTRL) midi_state = PS_CTRL_NUM;
                  else midi_state = PS_IDLE;
               end
            endcase
         end
         KIND_SAMPLE_LOAD: begin
            sample_mem[item.addr] = item.data[7:0];
            sample_known[item.addr] = 1'b1;
         end
         default: begin
            step_mem[item.addr[STEP_AW-1:0]] = item.data[STEP_WIDTH-1:0];
            step_known[item.addr[STEP_AW-1:0]] = 1'b1;
         end
      endcase
      res.level = play_level;
      res.playing = !play_stopped;
      return res;
   endfunction

   function automatic player_req_t random_req(input kind_type kind);
      player_req_t item;
      item.kind = kind;
      item.midi = 8'($urandom);
      item.addr = 15'($urandom);
      item.data = 16'($urandom);
      return item;
   endfunction

   // Low byte is zero now and then so that playback stops.
   function automatic logic [15:0] random_sample();
      logic [15:0] value;
      value = 16'($urandom);
      value[7:0] = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      return value;
   endfunction

   function automatic logic [15:0] random_step();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom);
         default: return 16'($urandom_range(256, 4096));
      endcase
   endfunction

   task automatic send_transfer(input player_req_t item, input logic typed,
                                input player_rsp_t typed_rsp);
      player_rsp_t predicted;
      if (!tail_phase && sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= item.kind;
      req_midi_byte <= item.midi;
      req_load_addr <= item.addr;
      req_load_data <= item.data;
      do @(posedge clock); while (req_stall);
      predicted = run_player(item);
      expected_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      if (items_sent % 100 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
   endtask

   // Writes any sample or step entry that the item is about to read and that was never loaded.
   task automatic offer_item(input player_req_t item, input logic typed,
                             input player_rsp_t typed_rsp);
      player_req_t fill;
      logic [STORE_AW-1:0] need;
      if (item.kind == KIND_TICK && !play_stopped
          && (play_pos >> FRACTION_BITS) < SLOT_LIMIT) begin
         need = sample_addr();
         if (!sample_known[need]) begin
            fill = random_req(KIND_SAMPLE_LOAD);
            fill.addr = need;
            fill.data = random_sample();
            send_transfer(fill, 1'b0, '0);
         end
      end
      if (item.kind == KIND_MIDI && midi_state == PS_VELOCITY && item.midi[6:0] != 7'd0
          && !step_known[midi_held]) begin
         fill = random_req(KIND_STEP_LOAD);
         fill.addr = {8'($urandom), midi_held};
         fill.data = random_step();
         send_transfer(fill, 1'b0, '0);
      end
      send_transfer(item, typed, typed_rsp);
   endtask

   task automatic report_failure(input string what, input player_rsp_t want,
                                 input player_rsp_t got);
      error_count++;
      if (error_count <= 10)
         $display("%0t ns: %s: expected level %02h updated %0b playing %0b,",
                  $realtime, what, want.level, want.updated, want.playing,
                  " got level %02h updated %0b playing %0b",
                  got.level, got.updated, got.playing);
   endtask

   // Result checking and receiver stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed = {rsp_audio_level, rsp_level_updated, rsp_playing};
         if (expected_results.size() == 0) begin
            report_failure("result transfer with nothing expected", '0, observed);
         end else begin
            awaited = expected_results.pop_front();
            if (observed !== awaited) report_failure("result mismatch", awaited, observed);
         end
         results_checked++;
         if (results_checked % 100 == 0) receiver_stalls = ($urandom_range(0, 2) != 0);
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && !tail_phase && results_checked >= HOLD_AT) begin
         // One long hold-off so that the block backs up and stalls its input.
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (!tail_phase && receiver_stalls && $urandom_range(0, 3) == 0) begin
         hold_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int          choice;
      logic [31:0] slot_addr;
      player_req_t item;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         offer_item({SCRIPT[i].kind, SCRIPT[i].midi, SCRIPT[i].addr, SCRIPT[i].data},
                    SCRIPT[i].typed,
                    {SCRIPT[i].level, SCRIPT[i].updated, SCRIPT[i].playing});
      end

      // Every transfer counts toward the total, store fills included.
      while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
         if (items_sent >= SCRIPT_ROWS + RANDOM_ITEMS - TAIL_ITEMS) tail_phase <= 1'b1;
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            offer_item(random_req(KIND_TICK), 1'b0, '0);
         end else if (choice < 60) begin
            // Note On message: status, note, velocity.
            item = random_req(KIND_MIDI);
            item.midi = MSG_NOTE_ON;
            offer_item(item, 1'b0, '0);
            offer_item(random_req(KIND_MIDI), 1'b0, '0);
            item = random_req(KIND_MIDI);
            if ($urandom_range(0, 9) == 0) item.midi[6:0] = 7'd0;
            offer_item(item, 1'b0, '0);
         end else if (choice < 68) begin
            item = random_req(KIND_MIDI);
            item.midi = MSG_CTRL;
            offer_item(item, 1'b0, '0);
            item = random_req(KIND_MIDI);
            if ($urandom_range(0, 3) != 0) item.midi[6:0] = CTRL_SLOT_SELECT;
            offer_item(item, 1'b0, '0);
            offer_item(random_req(KIND_MIDI), 1'b0, '0);
         end else if (choice < 82) begin
            item = random_req(KIND_SAMPLE_LOAD);
            item.data = random_sample();
            if ($urandom_range(0, 1) == 0) begin
               slot_addr = 32'(play_slot) * SLOT_SCALE + 32'($urandom_range(0, SLOT_LENGTH - 2));
               item.addr = slot_addr[STORE_AW-1:0];
            end
            offer_item(item, 1'b0, '0);
         end else if (choice < 89) begin
            item = random_req(KIND_STEP_LOAD);
            item.data = random_step();
            offer_item(item, 1'b0, '0);
         end else begin
            // Stray bytes and message heads with no data after them.
            item = random_req(KIND_MIDI);
            if ($urandom_range(0, 1) == 0)
               item.midi = ($urandom_range(0, 1) == 0) ? MSG_NOTE_ON : MSG_CTRL;
            offer_item(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> midi_wavetable_sample_player.f
+incdir+hdl
hdl/mwsp_pkg.sv
hdl/mwsp_ram.sv
hdl/midi_wavetable_sample_player.sv
hdl/mwsp_checker.sv
verif/tb_top.sv
